// ----- rtl/core/adp_pkg.sv -----
// Shared types, constants and helpers for the ArtDMX packet parser.
package adp_pkg;

   localparam int unsigned HDR_BYTES = 18;
   localparam int unsigned IDENT_BYTES = 8;
   localparam int unsigned POS_W = 17;
   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
   localparam logic [15:0] ARTDMX_OPCODE = 16'h5000;
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   typedef enum logic {
      KIND_DATA   = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      VERDICT_OK        = 3'd0,
      VERDICT_SHORT     = 3'd1,
      VERDICT_BAD_ID    = 3'd2,
      VERDICT_BAD_OP    = 3'd3,
      VERDICT_TRUNCATED = 3'd4
   } verdict_type;

   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_IDENT  = 2'd1,
      ERR_OPCODE = 2'd2
   } err_type;

   typedef struct packed {
      logic        has_data;
      logic        has_status;
      logic [7:0]  dmx_byte;
      logic [15:0] dmx_index;
      verdict_type verdict;
      logic [7:0]  seq_number;
      logic [7:0]  phys_port;
      logic [15:0] universe_id;
      logic [15:0] data_length;
   } cmd_type;

   function automatic logic [7:0] ident_byte(input logic [2:0] idx);
      logic [7:0] val;
      unique case (idx)
         3'd0: val = 8'h41;
         3'd1: val = 8'h72;
         3'd2: val = 8'h74;
         3'd3: val = 8'h2D;
         3'd4: val = 8'h4E;
         3'd5: val = 8'h65;
         3'd6: val = 8'h74;
         3'd7: val = 8'h00;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

// ----- rtl/core/adp_req_if.sv -----
// Input byte channel: valid/ready with one payload byte and an end flag.
interface adp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       packet_end;

   modport source(output valid, byte_value, packet_end, input ready);
   modport sink(input valid, byte_value, packet_end, output ready);
endinterface

// ----- rtl/core/adp_rsp_if.sv -----
// Result channel: valid/ready with DMX data or end-of-packet status.
interface adp_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [7:0]  dmx_byte;
   logic [15:0] dmx_index;
   logic [2:0]  verdict;
   logic [7:0]  seq_number;
   logic [7:0]  phys_port;
   logic [15:0] universe_id;
   logic [15:0] data_length;
   logic        run_end;

   modport source(output valid, result_kind, dmx_byte, dmx_index, verdict, seq_number,
                  phys_port, universe_id, data_length, run_end, input ready);
   modport sink(input valid, result_kind, dmx_byte, dmx_index, verdict, seq_number,
                phys_port, universe_id, data_length, run_end, output ready);
endinterface

// ----- rtl/core/adp_front.sv -----
// Front end: tracks byte position, checks and captures the header, classifies each byte.
module adp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         byte_value,
   input  logic               packet_end,
   output logic               push,
   output adp_pkg::cmd_type   push_cmd
);

   logic [adp_pkg::POS_W-1:0] pos_ff, pos_in;
   adp_pkg::err_type          err_ff, err_in;
   logic [7:0]                oplo_ff, oplo_in;
   logic [7:0]                seq_ff, seq_in;
   logic [7:0]                phys_ff, phys_in;
   logic [15:0]               univ_ff, univ_in;
   logic [15:0]               len_ff, len_in;

   logic [adp_pkg::POS_W-1:0] total;
   logic [adp_pkg::POS_W-1:0] data_off;
   logic [adp_pkg::POS_W-1:0] need;
   logic                      data_hit;
   adp_pkg::verdict_type      verdict;

   always_comb begin
      err_in  = err_ff;
      oplo_in = oplo_ff;
      seq_in  = seq_ff;
      phys_in = phys_ff;
      univ_in = univ_ff;
      len_in  = len_ff;
      data_off = pos_ff - adp_pkg::POS_W'(adp_pkg::HDR_BYTES);
      data_hit = 1'b0;
      priority if (pos_ff < adp_pkg::POS_W'(adp_pkg::IDENT_BYTES)) begin
         if (byte_value != adp_pkg::ident_byte(pos_ff[2:0]) && err_ff == adp_pkg::ERR_NONE)
            err_in = adp_pkg::ERR_IDENT;
      end else if (pos_ff == adp_pkg::POS_W'(8)) begin
         oplo_in = byte_value;
      end else if (pos_ff == adp_pkg::POS_W'(9)) begin
         if ({byte_value, oplo_ff} != adp_pkg::ARTDMX_OPCODE && err_ff == adp_pkg::ERR_NONE)
            err_in = adp_pkg::ERR_OPCODE;
      end else if (pos_ff == adp_pkg::POS_W'(12)) begin
         seq_in = byte_value;
      end else if (pos_ff == adp_pkg::POS_W'(13)) begin
         phys_in = byte_value;
      end else if (pos_ff == adp_pkg::POS_W'(14)) begin
         univ_in = {univ_ff[15:8], byte_value};
      end else if (pos_ff == adp_pkg::POS_W'(15)) begin
         univ_in = {byte_value, univ_ff[7:0]};
      end else if (pos_ff == adp_pkg::POS_W'(16)) begin
         len_in = {byte_value, len_ff[7:0]};
      end else if (pos_ff == adp_pkg::POS_W'(17)) begin
         len_in = {len_ff[15:8], byte_value};
      end else if (pos_ff >= adp_pkg::POS_W'(adp_pkg::HDR_BYTES)) begin
         data_hit = (err_ff == adp_pkg::ERR_NONE) && (data_off < {1'b0, len_ff});
      end else begin
         data_hit = 1'b0;
      end
   end

   assign total = (pos_ff == adp_pkg::POS_MAX) ? pos_ff : pos_ff + 1'b1;
   assign need  = adp_pkg::POS_W'(adp_pkg::HDR_BYTES) + {1'b0, len_in};

   always_comb begin
      priority if (total < adp_pkg::POS_W'(adp_pkg::HDR_BYTES))
         verdict = adp_pkg::VERDICT_SHORT;
      else if (err_in == adp_pkg::ERR_IDENT)
         verdict = adp_pkg::VERDICT_BAD_ID;
      else if (err_in == adp_pkg::ERR_OPCODE)
         verdict = adp_pkg::VERDICT_BAD_OP;
      else if (total < need)
         verdict = adp_pkg::VERDICT_TRUNCATED;
      else
         verdict = adp_pkg::VERDICT_OK;
   end

   always_comb begin
      push_cmd.has_data    = data_hit;
      push_cmd.has_status  = packet_end;
      push_cmd.dmx_byte    = byte_value;
      push_cmd.dmx_index   = data_off[15:0];
      push_cmd.verdict     = verdict;
      push_cmd.seq_number  = seq_in;
      push_cmd.phys_port   = phys_in;
      push_cmd.universe_id = univ_in;
      push_cmd.data_length = len_in;
   end

   assign push = accept && (data_hit || packet_end);

   always_ff @(posedge clock) begin
      if (reset || (accept && packet_end)) begin
         pos_ff  <= '0;
         err_ff  <= adp_pkg::ERR_NONE;
         oplo_ff <= '0;
         seq_ff  <= '0;
         phys_ff <= '0;
         univ_ff <= '0;
         len_ff  <= '0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         err_ff  <= err_in;
         oplo_ff <= oplo_in;
         seq_ff  <= seq_in;
         phys_ff <= phys_in;
         univ_ff <= univ_in;
         len_ff  <= len_in;
      end
   end

   assign pos_in = total;

endmodule

// ----- rtl/core/adp_queue.sv -----
// Short command queue between the front end and the result sequencer.
module adp_queue #(
   parameter int unsigned Depth = adp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  adp_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output adp_pkg::cmd_type head_cmd
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(Depth);

   adp_pkg::cmd_type mem_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CntFull);
   assign head_valid = (count_ff != '0);
   assign head_cmd   = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (do_pop && !do_push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         mem_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

// ----- rtl/core/adp_back.sv -----
// Result sequencer: expands each queued command into one or two registered results.
module adp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  adp_pkg::cmd_type  head_cmd,
   output logic              pop,
   adp_rsp_if.source         rsp_ch
);

   typedef enum logic {
      PH_DATA,
      PH_STATUS
   } phase_type;

   adp_pkg::cmd_type cur_ff, cur_in;
   logic             valid_ff, valid_in;
   phase_type        phase_ff, phase_in;
   logic             taken, done, advance;

   assign taken   = valid_ff && rsp_ch.ready;
   assign done    = taken && (phase_ff == PH_STATUS || !cur_ff.has_status);
   assign advance = taken && phase_ff == PH_DATA && cur_ff.has_status;
   assign pop     = head_valid && (!valid_ff || done);

   always_comb begin
      cur_in   = cur_ff;
      valid_in = valid_ff;
      phase_in = phase_ff;
      priority if (pop) begin
         cur_in   = head_cmd;
         valid_in = 1'b1;
         phase_in = head_cmd.has_data ? PH_DATA : PH_STATUS;
      end else if (done) begin
         valid_in = 1'b0;
      end else if (advance) begin
         phase_in = PH_STATUS;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= PH_DATA;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
      cur_ff <= cur_in;
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.result_kind = (phase_ff == PH_STATUS) ? adp_pkg::KIND_STATUS
                                                       : adp_pkg::KIND_DATA;
   assign rsp_ch.dmx_byte    = (phase_ff == PH_STATUS) ? 8'd0 : cur_ff.dmx_byte;
   assign rsp_ch.dmx_index   = (phase_ff == PH_STATUS) ? 16'd0 : cur_ff.dmx_index;
   assign rsp_ch.verdict     = (phase_ff == PH_STATUS) ? cur_ff.verdict
                                                       : adp_pkg::VERDICT_OK;
   assign rsp_ch.seq_number  = cur_ff.seq_number;
   assign rsp_ch.phys_port   = cur_ff.phys_port;
   assign rsp_ch.universe_id = cur_ff.universe_id;
   assign rsp_ch.data_length = cur_ff.data_length;
   assign rsp_ch.run_end     = (phase_ff == PH_STATUS) || !cur_ff.has_status;

endmodule

// ----- rtl/core/artnet_dmx_packet_parser.sv -----
// ArtDMX packet parser top level: front end, command queue and result sequencer.
//
// req_ch takes one UDP payload byte per item, packet_end marking the last
// byte. The front end checks the "Art-Net" identifier and opcode 0x5000,
// captures sequence, physical port, universe and length, and turns each
// byte into at most one command: a DMX data byte, an end-of-packet status,
// or both. rsp_ch returns the results; a data byte on the final byte comes
// out first, then the status, which carries run_end.
// Each result passes through the command queue and the output register.
// Throughput: one byte per cycle while the queue has room. A final data
// byte gives two results; the queue of QueueDepth commands absorbs this.
// req_ch.ready drops only when the queue is full, which happens when rsp_ch
// is stalled; bytes that produce no result still need a free slot.
// Reset clears the queue and the output register and puts the parser at
// the start of a packet.
module artnet_dmx_packet_parser #(
   parameter int unsigned QueueDepth = adp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   adp_req_if.sink   req_ch,
   adp_rsp_if.source rsp_ch
);

   logic             accept;
   logic             push;
   adp_pkg::cmd_type push_cmd;
   logic             full;
   logic             pop;
   logic             head_valid;
   adp_pkg::cmd_type head_cmd;

   assign req_ch.ready = !full;
   assign accept       = req_ch.valid && !full;

   adp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .byte_value (req_ch.byte_value),
      .packet_end (req_ch.packet_end),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   adp_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   adp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

// ----- rtl/core/adp_checker.sv -----
// Port-level assertions for the ArtDMX packet parser and their bind.
module adp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_result_kind,
   input logic [7:0]  rsp_dmx_byte,
   input logic [15:0] rsp_dmx_index,
   input logic [2:0]  rsp_verdict,
   input logic        rsp_run_end
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind)
         && $stable(rsp_dmx_byte) && $stable(rsp_dmx_index) && $stable(rsp_verdict))
      else $error("result changed while stalled");

   a_status_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == adp_pkg::KIND_STATUS
         |-> rsp_dmx_byte == 8'd0 && rsp_dmx_index == 16'd0 && rsp_run_end)
      else $error("status item malformed");

   a_data_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == adp_pkg::KIND_DATA |-> rsp_verdict == adp_pkg::VERDICT_OK)
      else $error("data item with nonzero verdict");

   a_status_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_result_kind == adp_pkg::KIND_DATA && !rsp_run_end
         |=> rsp_valid && rsp_result_kind == adp_pkg::KIND_STATUS)
      else $error("status did not follow final data item");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

endmodule

bind artnet_dmx_packet_parser adp_checker u_adp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_result_kind (rsp_ch.result_kind),
   .rsp_dmx_byte    (rsp_ch.dmx_byte),
   .rsp_dmx_index   (rsp_ch.dmx_index),
   .rsp_verdict     (rsp_ch.verdict),
   .rsp_run_end     (rsp_ch.run_end)
);

// ----- bench/artnet_dmx_packet_parser_check.sv -----
// Result checker for the ArtDMX parser: predicts results per input byte and compares.
`timescale 1ns / 100ps

module artnet_dmx_packet_parser_check
   import adp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   adp_req_if   req_mon,
   adp_rsp_if   rsp_mon,
   output int   failures,
   output int   pending,
   output int   data_seen,
   output int   status_seen
);

   localparam logic [63:0] ARTNET_ID = {8'h00, "t", "e", "N", "-", "t", "r", "A"};

   typedef struct {
      kind_type    kind;
      logic [7:0]  dmx_byte;
      logic [15:0] dmx_index;
      verdict_type verdict;
      logic [7:0]  seq_number;
      logic [7:0]  phys_port;
      logic [15:0] universe_id;
      logic [15:0] data_length;
      logic        run_end;
   } dmx_result_type;

   dmx_result_type expected_results[$];

   logic [POS_W-1:0] byte_pos;
   err_type          hdr_err;
   logic [7:0]       opcode_lo;
   logic [7:0]       seq_cap;
   logic [7:0]       phys_cap;
   logic [15:0]      universe_cap;
   logic [15:0]      length_cap;

   task automatic clear_packet();
      byte_pos = '0;
      hdr_err = ERR_NONE;
      opcode_lo = '0;
      seq_cap = '0;
      phys_cap = '0;
      universe_cap = '0;
      length_cap = '0;
   endtask

   function automatic dmx_result_type form_result(kind_type kind, logic [7:0] dbyte,
                                                  logic [15:0] didx, verdict_type v,
                                                  logic last);
      dmx_result_type r;
      r.kind = kind;
      r.dmx_byte = dbyte;
      r.dmx_index = didx;
      r.verdict = v;
      r.seq_number = seq_cap;
      r.phys_port = phys_cap;
      r.universe_id = universe_cap;
      r.data_length = length_cap;
      r.run_end = last;
      return r;
   endfunction

   task automatic parse_byte(input logic [7:0] b, input logic last);
      logic [POS_W-1:0] total;
      int unsigned      d;
      verdict_type      v;
      if (byte_pos < IDENT_BYTES) begin
         if (b != ARTNET_ID[byte_pos[2:0]*8 +: 8] && hdr_err == ERR_NONE) hdr_err = ERR_IDENT;
      end else if (byte_pos == 8) begin
         opcode_lo = b;
      end else if (byte_pos == 9) begin
         if ({b, opcode_lo} != ARTDMX_OPCODE && hdr_err == ERR_NONE) hdr_err = ERR_OPCODE;
      end else if (byte_pos == 12) begin
         seq_cap = b;
      end else if (byte_pos == 13) begin
         phys_cap = b;
      end else if (byte_pos == 14) begin
         universe_cap[7:0] = b;
      end else if (byte_pos == 15) begin
         universe_cap[15:8] = b;
      end else if (byte_pos == 16) begin
         length_cap[15:8] = b;
      end else if (byte_pos == 17) begin
         length_cap[7:0] = b;
      end else if (byte_pos >= HDR_BYTES) begin
         d = byte_pos - HDR_BYTES;
         if (hdr_err == ERR_NONE && d < length_cap)
            expected_results.insert(expected_results.size(),
                                    form_result(KIND_DATA, b, d[15:0], VERDICT_OK, !last));
      end

      total = (byte_pos != POS_MAX) ? byte_pos + 1'b1 : POS_MAX;
      byte_pos = total;

      if (last) begin
         if (total < HDR_BYTES) v = VERDICT_SHORT;
         else if (hdr_err == ERR_IDENT) v = VERDICT_BAD_ID;
         else if (hdr_err == ERR_OPCODE) v = VERDICT_BAD_OP;
         else if (total < HDR_BYTES + length_cap) v = VERDICT_TRUNCATED;
         else v = VERDICT_OK;
         expected_results.insert(expected_results.size(),
                                 form_result(KIND_STATUS, 8'h00, 16'h0000, v, 1'b1));
         clear_packet();
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] exp_v,
                              input logic [15:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         failures++;
      end
   endtask

   task automatic check_result();
      dmx_result_type e;
      if (expected_results.size() == 0) begin
         $error("result item with none expected (kind %0b)", rsp_mon.result_kind);
         failures++;
      end else begin
         e = expected_results.pop_front();
         check_field("result_kind", 16'(e.kind), 16'(rsp_mon.result_kind));
         check_field("dmx_byte", 16'(e.dmx_byte), 16'(rsp_mon.dmx_byte));
         check_field("dmx_index", e.dmx_index, rsp_mon.dmx_index);
         check_field("verdict", 16'(e.verdict), 16'(rsp_mon.verdict));
         check_field("seq_number", 16'(e.seq_number), 16'(rsp_mon.seq_number));
         check_field("phys_port", 16'(e.phys_port), 16'(rsp_mon.phys_port));
         check_field("universe_id", e.universe_id, rsp_mon.universe_id);
         check_field("data_length", e.data_length, rsp_mon.data_length);
         check_field("run_end", 16'(e.run_end), 16'(rsp_mon.run_end));
         if (e.kind == KIND_DATA) data_seen++;
         else status_seen++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_packet();
         expected_results.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) parse_byte(req_mon.byte_value, req_mon.packet_end);
         if (rsp_mon.valid && rsp_mon.ready) check_result();
      end
      pending = expected_results.size();
   end

endmodule

// ----- bench/artnet_dmx_packet_parser_test.sv -----
// Testbench top for the ArtDMX parser: clock, reset, packet stimulus and verdict.
`timescale 1ns / 100ps

module artnet_dmx_packet_parser_test;
   import adp_pkg::*;

   localparam logic [63:0] ARTNET_ID = {8'h00, "t", "e", "N", "-", "t", "r", "A"};
   localparam int RANDOM_ITEMS = 500;

   typedef enum {
      PKT_GOOD, PKT_EXTRA, PKT_TRUNC, PKT_BAD_ID, PKT_BAD_OP, PKT_BAD_BOTH, PKT_SHORT, PKT_NOISE
   } pkt_class_type;

   logic clock = 1'b0;
   logic reset;

   adp_req_if req_ch();
   adp_rsp_if rsp_ch();

   int failures, pending, data_seen, status_seen;
   int item_count, packet_count;
   bit fast_mode, req_idle_on, rsp_idle_on;

   logic [7:0] pkt_bytes[$];

   artnet_dmx_packet_parser DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   artnet_dmx_packet_parser_check dmx_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .failures    (failures),
      .pending     (pending),
      .data_seen   (data_seen),
      .status_seen (status_seen)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #4_000_000;
      $display("artnet_dmx_packet_parser_test: FAIL");
      $finish;
   end

   // result side: random stall before each item, none in quiet stretches
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      @(negedge clock);
      forever begin
         stall = (fast_mode || !rsp_idle_on) ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // drop valid and hold off until every expected result has come
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   task automatic add_byte(input logic [7:0] b);
      pkt_bytes.insert(pkt_bytes.size(), b);
   endtask

   task automatic put_data(input int n);
      repeat (n) add_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic put_header(input logic [7:0] seq, input logic [7:0] phys,
                             input logic [15:0] univ, input logic [15:0] len);
      for (int i = 0; i < IDENT_BYTES; i++) add_byte(ARTNET_ID[i*8 +: 8]);
      add_byte(ARTDMX_OPCODE[7:0]);
      add_byte(ARTDMX_OPCODE[15:8]);
      put_data(2);
      add_byte(seq);
      add_byte(phys);
      add_byte(univ[7:0]);
      add_byte(univ[15:8]);
      add_byte(len[15:8]);
      add_byte(len[7:0]);
   endtask

   task automatic send_packet();
      int gap;
      int last_idx;
      last_idx = pkt_bytes.size() - 1;
      req_idle_on = $urandom_range(0, 3) != 0;
      rsp_idle_on = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 7) == 0) wait_drained();
      for (int i = 0; i <= last_idx; i++) begin
         gap = (fast_mode || !req_idle_on) ? 0 : $urandom_range(0, 19);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_ch.valid <= 1'b1;
         req_ch.byte_value <= pkt_bytes[i];
         req_ch.packet_end <= (i == last_idx);
         @(posedge clock);
         while (!req_ch.ready) @(posedge clock);
         @(negedge clock);
         item_count++;
      end
      pkt_bytes.delete();
      packet_count++;
   endtask

   task automatic make_random_packet();
      pkt_class_type cls;
      logic [15:0]   len;
      int            n;
      int            k;
      case ($urandom_range(0, 11))
         0, 1, 2, 3: cls = PKT_GOOD;
         4, 5: cls = PKT_EXTRA;
         6: cls = PKT_TRUNC;
         7: cls = PKT_BAD_ID;
         8: cls = PKT_BAD_OP;
         9: cls = PKT_BAD_BOTH;
         10: cls = PKT_SHORT;
         default: cls = PKT_NOISE;
      endcase
      len = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(13, 40))
                                        : 16'($urandom_range(0, 12));
      n = int'(len);
      case (cls)
         PKT_EXTRA: n = int'(len) + $urandom_range(1, 6);
         PKT_TRUNC: begin
            if ($urandom_range(0, 1) == 0) begin
               len = 16'($urandom_range(13, 65535));
               n = $urandom_range(0, 12);
            end else begin
               len = 16'($urandom_range(1, 12));
               n = $urandom_range(0, len - 1);
            end
         end
         PKT_BAD_ID, PKT_BAD_OP, PKT_BAD_BOTH: n = $urandom_range(0, 12);
         default: ;
      endcase
      if (cls == PKT_NOISE) begin
         put_data($urandom_range(1, 30));
      end else begin
         put_header(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    16'($urandom_range(0, 65535)), len);
         put_data(n);
         if (cls == PKT_BAD_ID || cls == PKT_BAD_BOTH) begin
            k = $urandom_range(0, IDENT_BYTES - 1);
            pkt_bytes[k] = pkt_bytes[k] ^ 8'($urandom_range(1, 255));
         end
         if (cls == PKT_BAD_OP || cls == PKT_BAD_BOTH) begin
            k = $urandom_range(8, 9);
            pkt_bytes[k] = pkt_bytes[k] ^ 8'($urandom_range(1, 255));
         end
         if (cls == PKT_SHORT) begin
            k = $urandom_range(1, HDR_BYTES - 1);
            while (pkt_bytes.size() > k) void'(pkt_bytes.pop_back());
         end
      end
   endtask

   initial begin
      int random_start;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.byte_value <= 8'h00;
      req_ch.packet_end <= 1'b0;
      fast_mode = 1'b0;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // single-byte packet, then a bare header with no data
      add_byte(8'hFF);
      send_packet();
      put_header(8'hFF, 8'h00, 16'hFFFF, 16'h0000);
      send_packet();
      wait_drained();

      random_start = item_count;
      while (item_count - random_start < RANDOM_ITEMS) begin
         make_random_packet();
         send_packet();
      end

      // back-to-back burst with no idling on either side
      wait_drained();
      fast_mode = 1'b1;
      repeat (2) begin
         put_header(8'h5A, 8'hA5, 16'hFFFF, 16'd24);
         put_data(28);
         send_packet();
      end
      fast_mode = 1'b0;

      wait_drained();
      repeat (8) @(negedge clock);
      $display("Sent %0d bytes in %0d packets of every header class, ending in a full-rate burst;",
               item_count, packet_count);
      $display("checked %0d DMX data and %0d status items.", data_seen, status_seen);
      if (failures == 0 && pending == 0) begin
         $display("artnet_dmx_packet_parser_test: PASS");
      end else begin
         $display("artnet_dmx_packet_parser_test: FAIL");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/adp_pkg.sv
rtl/core/adp_req_if.sv
rtl/core/adp_rsp_if.sv
rtl/core/adp_front.sv
rtl/core/adp_queue.sv
rtl/core/adp_back.sv
rtl/core/artnet_dmx_packet_parser.sv
rtl/core/adp_checker.sv
bench/artnet_dmx_packet_parser_check.sv
bench/artnet_dmx_packet_parser_test.sv
